// File: hdl/sorted_key_table_unit_macros.svh
// Assertion helpers for the sorted key table unit.
// Both macros sample on clk_i and are switched off while rst_ni is low.
`ifndef SORTED_KEY_TABLE_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_UNIT_MACROS_SVH

// Check a property at every clock edge.
`define SKT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants, codes and types of the sorted key table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int CAPACITY      = 16;
  localparam int PAYLOAD_WIDTH = 16;
  localparam int KEY_WIDTH     = 32;
  localparam int KIND_WIDTH    = 2;
  localparam int COUNT_WIDTH   = $clog2(CAPACITY + 1);

  // Operation codes carried in the kind field
  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  // Broadcast from the control logic to every cell
  typedef struct packed {
    logic                            ins_en;
    logic                            rem_en;
    logic signed [KEY_WIDTH-1:0]     key;
    logic        [PAYLOAD_WIDTH-1:0] payload;
  } cell_cmd_t;

  // Compare flags a cell hands to its right neighbor
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flag_t;

  // Entry held by one cell
  typedef struct packed {
    logic signed [KEY_WIDTH-1:0]     key;
    logic        [PAYLOAD_WIDTH-1:0] payload;
  } entry_t;

endpackage

`default_nettype wire

// File: hdl/skt_channels.sv
// ----------------------------------------------------------------------------
// skt_in_if / skt_out_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface skt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [skt_pkg::KIND_WIDTH-1:0] kind;
  logic signed [skt_pkg::KEY_WIDTH-1:0]  key;
  logic [skt_pkg::PAYLOAD_WIDTH-1:0]     payload;

  modport source (output valid, kind, key, payload, input ready);
  modport sink   (input valid, kind, key, payload, output ready);
endinterface

interface skt_out_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic [skt_pkg::PAYLOAD_WIDTH-1:0]   found_payload;
  logic [skt_pkg::COUNT_WIDTH-1:0]     entry_count;

  modport source (output valid, ok, found_payload, entry_count, input ready);
  modport sink   (input valid, ok, found_payload, entry_count, output ready);
endinterface

`default_nettype wire

// File: hdl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One table position: holds an entry, compares it with the request key and
// shifts in from the left (insert) or from the right (remove).
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell (
  input  wire logic                clk_i,
  input  wire skt_pkg::cell_cmd_t  cmd_i,
  input  wire logic                occ_i,
  input  wire skt_pkg::cell_flag_t left_flag_i,
  input  wire skt_pkg::entry_t     left_entry_i,
  input  wire skt_pkg::entry_t     right_entry_i,
  output skt_pkg::cell_flag_t      flag_o,
  output skt_pkg::entry_t          entry_o,
  output logic                     hit_o
);

  skt_pkg::entry_t entry_q, entry_d;
  skt_pkg::entry_t new_entry;

  // Compare the stored key against the request key
  assign flag_o.lt = occ_i && (entry_q.key < cmd_i.key);
  assign flag_o.eq = occ_i && (entry_q.key == cmd_i.key);

  // Equal keys sit side by side, so the first match has no match on its left
  assign hit_o   = flag_o.eq && !left_flag_i.eq;
  assign entry_o = entry_q;

  assign new_entry.key     = cmd_i.key;
  assign new_entry.payload = cmd_i.payload;

  // Keep entries below the request key, shift the rest
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en && !flag_o.lt) begin
      entry_d = left_flag_i.lt ? new_entry : left_entry_i;
    end else if (cmd_i.rem_en && !flag_o.lt) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// File: hdl/sorted_key_table_unit.sv
// The result word is registered and appears in the cycle after its request word is accepted.
// Throughput: one request per cycle while the result side takes every word;
// every cell compares its key in the same cycle, so the 32-bit compare in the
// cells plus the match reduction across the row sets the cycle.
// Reset clears the entry count and the result valid; cell contents stay
// unknown until written and are never read beyond the entry count.
// ----------------------------------------------------------------------------
// sorted_key_table_unit
// Sorted table of keyed entries built as a row of shifting cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_table_unit_macros.svh"

module sorted_key_table_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  skt_in_if.sink    in_ch_i,
  skt_out_if.source out_ch_o
);

  localparam int Cap = skt_pkg::CAPACITY;
  localparam int Cw  = skt_pkg::COUNT_WIDTH;
  localparam int Pw  = skt_pkg::PAYLOAD_WIDTH;

  logic [Cw-1:0]       count_q, count_d;
  logic                out_valid_q;
  logic                ok_q, ok_d;
  logic [Pw-1:0]       found_q, found_d;
  logic                accept;
  logic                any_hit;
  logic                not_full;
  logic [Cap-1:0]      occ;
  logic [Cap-1:0]      hit;
  logic [Pw-1:0]       hit_payload;
  skt_pkg::cell_cmd_t  cmd;
  skt_pkg::cell_flag_t flag     [Cap];
  skt_pkg::entry_t     entry    [Cap];
  skt_pkg::cell_flag_t left_flag;
  skt_pkg::entry_t     blank_entry;

  // Take a new word when the result register is empty or being drained
  assign in_ch_i.ready = !out_valid_q || out_ch_o.ready;
  assign accept        = in_ch_i.valid && in_ch_i.ready;
  assign not_full      = count_q < Cw'(Cap);

  // Cell zero sees a smaller neighbor and no match on its left
  assign left_flag.lt  = 1'b1;
  assign left_flag.eq  = 1'b0;
  assign blank_entry   = '0;

  assign any_hit = |hit;

  // Pick the payload of the first match
  always_comb begin
    hit_payload = '0;
    for (int i = 0; i < Cap; i++) begin
      hit_payload = hit_payload | (hit[i] ? entry[i].payload : '0);
    end
  end

  // Decode the request word into the broadcast command
  always_comb begin
    cmd.key     = in_ch_i.key;
    cmd.payload = in_ch_i.payload;
    cmd.ins_en  = 1'b0;
    cmd.rem_en  = 1'b0;
    ok_d        = 1'b0;
    found_d     = '0;
    count_d     = count_q;
    case (in_ch_i.kind)
      skt_pkg::KIND_INSERT: begin
        ok_d       = not_full;
        cmd.ins_en = accept && not_full;
        if (cmd.ins_en) begin
          count_d = count_q + Cw'(1);
        end
      end
      skt_pkg::KIND_FIND: begin
        ok_d    = any_hit;
        found_d = hit_payload;
      end
      skt_pkg::KIND_REMOVE: begin
        ok_d       = any_hit;
        cmd.rem_en = accept && any_hit;
        if (cmd.rem_en) begin
          count_d = count_q - Cw'(1);
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Row of cells
  for (genvar i = 0; i < Cap; i++) begin : g_cell
    assign occ[i] = Cw'(i) < count_q;
    if (i == 0) begin : g_first
      skt_cell u_cell (
        .clk_i         (clk_i),
        .cmd_i         (cmd),
        .occ_i         (occ[i]),
        .left_flag_i   (left_flag),
        .left_entry_i  (blank_entry),
        .right_entry_i (entry[i+1]),
        .flag_o        (flag[i]),
        .entry_o       (entry[i]),
        .hit_o         (hit[i])
      );
    end else if (i == Cap - 1) begin : g_last
      skt_cell u_cell (
        .clk_i         (clk_i),
        .cmd_i         (cmd),
        .occ_i         (occ[i]),
        .left_flag_i   (flag[i-1]),
        .left_entry_i  (entry[i-1]),
        .right_entry_i (blank_entry),
        .flag_o        (flag[i]),
        .entry_o       (entry[i]),
        .hit_o         (hit[i])
      );
    end else begin : g_mid
      skt_cell u_cell (
        .clk_i         (clk_i),
        .cmd_i         (cmd),
        .occ_i         (occ[i]),
        .left_flag_i   (flag[i-1]),
        .left_entry_i  (entry[i-1]),
        .right_entry_i (entry[i+1]),
        .flag_o        (flag[i]),
        .entry_o       (entry[i]),
        .hit_o         (hit[i])
      );
    end
  end

  // Entry count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q    <= ok_d;
      found_q <= found_d;
    end
  end

  assign out_ch_o.valid         = out_valid_q;
  assign out_ch_o.ok            = ok_q;
  assign out_ch_o.found_payload = found_q;
  assign out_ch_o.entry_count   = count_q;

  `SKT_ASSERT(a_count_bound, count_q <= Cw'(Cap), "entry count above capacity")
  `SKT_ASSERT(a_single_hit, $onehot0(hit), "more than one first match")
  `SKT_ASSERT_NEXT(a_insert_count, cmd.ins_en, count_q == $past(count_q) + Cw'(1), "insert count")
  `SKT_ASSERT_NEXT(a_remove_count, cmd.rem_en, count_q == $past(count_q) - Cw'(1), "remove count")

endmodule

`default_nettype wire
